@@ hw/rtl/lkv_pkg.sv @@
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_TOUCH,
        MODE_INSERT,
        MODE_REPLACE
    } lkv_mode_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        lkv_mode_t          mode;
        logic               wr_value;
        logic [RANK_W-1:0]  ref_rank;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } lkv_cmd_t;

    // what a cell reports back
    typedef struct packed {
        logic               valid;
        logic               match;
        logic [RANK_W-1:0]  rank;
        logic [VAL_W-1:0]   value;
    } lkv_cell_t;

endpackage

@@ hw/rtl/lkv_cell.sv @@
module lkv_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkv_pkg::lkv_cmd_t    cmd,
    input  logic                 free_in,
    output logic                 free_out,
    output lkv_pkg::lkv_cell_t   status
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lkv_pkg::RANK_W-1:0]    rank_reg;
    logic [lkv_pkg::RANK_W-1:0]    rank_next;
    logic [lkv_pkg::KEY_W-1:0]     key_reg;
    logic [lkv_pkg::VAL_W-1:0]     value_reg;
    logic                          match;
    logic                          target;
    logic                          age;

    assign match    = valid_reg && (key_reg == cmd.key);
    // a free cell somewhere at or below this one
    assign free_out = free_in || !valid_reg;

    always_comb
    begin
        case (cmd.mode)
            lkv_pkg::MODE_TOUCH:   target = match;
            lkv_pkg::MODE_INSERT:  target = !valid_reg && !free_in;
            lkv_pkg::MODE_REPLACE: target = valid_reg && (rank_reg == cmd.ref_rank);
            default:               target = 1'b0;
        endcase

        case (cmd.mode)
            lkv_pkg::MODE_INSERT:  age = valid_reg;
            lkv_pkg::MODE_TOUCH,
            lkv_pkg::MODE_REPLACE: age = valid_reg && (rank_reg < cmd.ref_rank);
            default:               age = 1'b0;
        endcase

        valid_next = valid_reg || (target && (cmd.mode == lkv_pkg::MODE_INSERT));

        if (target)
        begin
            rank_next = '0;
        end
        else if (age)
        begin
            rank_next = rank_reg + 1'b1;
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (target && (cmd.mode != lkv_pkg::MODE_TOUCH))
        begin
            key_reg <= cmd.key;
        end
        if (target && cmd.wr_value)
        begin
            value_reg <= cmd.value;
        end
    end

    assign status.valid = valid_reg;
    assign status.match = match;
    assign status.rank  = rank_reg;
    assign status.value = value_reg;

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-used replacement.
//
// Input channel (in_valid/in_ready): op, key, value. A set (op=1) writes or
// updates an entry and gives no result item; a get (op=0) gives one result
// item on the output channel (out_valid/out_ready): hit and read_value,
// read_value being zero on a miss.
// An accepted item is held in a pending register and is executed from there
// against all cells at once; a get result is registered, so it passes the
// pending register and then the output register before it appears.
// Throughput is one item per cycle while no get waits on a stalled output:
// the cell row finishes a lookup and its rank update in the same cycle.
// When the receiver stalls, the waiting result holds in the output register;
// a pending get then waits, which drops in_ready. Sets keep flowing as long
// as nothing is pending behind a blocked get.
// The capacity register (APB, offset 0) limits the fill before eviction.
// Reset clears all valid bits and ranks, the fill count and sets capacity
// to 16; no clearing pass is needed.
module lru_key_value_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]    paddr,
    input  logic [lkv_pkg::DATA_W-1:0]    pwdata,
    output logic [lkv_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [lkv_pkg::KEY_W-1:0]     key,
    input  logic [lkv_pkg::VAL_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [lkv_pkg::VAL_W-1:0]     read_value
);

    logic [lkv_pkg::CAP_W-1:0]      capacity_reg;
    logic [lkv_pkg::CNT_W-1:0]      count_reg;
    logic [lkv_pkg::CNT_W-1:0]      count_next;
    logic [lkv_pkg::CNT_W-1:0]      cap_eff;
    logic [lkv_pkg::CNT_W-1:0]      count_m1;

    logic                           pend_valid_reg;
    logic                           pend_op_reg;
    logic [lkv_pkg::KEY_W-1:0]      pend_key_reg;
    logic [lkv_pkg::VAL_W-1:0]      pend_value_reg;

    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [lkv_pkg::VAL_W-1:0]      read_value_reg;

    logic                           exec_go;
    logic                           in_fire;
    logic                           cfg_wr;
    logic                           any_match;
    logic [lkv_pkg::RANK_W-1:0]     match_rank;
    logic [lkv_pkg::VAL_W-1:0]      match_value;
    logic [lkv_pkg::MAX_ENTRIES-1:0] valid_vec;
    logic [lkv_pkg::MAX_ENTRIES-1:0] match_vec;

    lkv_pkg::lkv_cmd_t              cmd;
    lkv_pkg::lkv_cell_t             cell_status [lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::MAX_ENTRIES:0]  free_chain;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[lkv_pkg::ADDR_W-1:2] == lkv_pkg::REG_CAPACITY);

    always_comb
    begin
        prdata = '0;
        if (paddr[lkv_pkg::ADDR_W-1:2] == lkv_pkg::REG_CAPACITY)
        begin
            prdata = lkv_pkg::DATA_W'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = lkv_pkg::CNT_W'(1);
        end
        else if (int'(capacity_reg) > lkv_pkg::MAX_ENTRIES)
        begin
            cap_eff = lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES);
        end
        else
        begin
            cap_eff = lkv_pkg::CNT_W'(capacity_reg);
        end
    end

    // handshake: a get waits while its result register is still occupied
    assign exec_go   = pend_valid_reg
                       && ((pend_op_reg == lkv_pkg::OP_SET) || !out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || exec_go;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (exec_go)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_op_reg    <= op;
            pend_key_reg   <= key;
            pend_value_reg <= value;
        end
    end

    // gather the cell row
    always_comb
    begin
        match_rank  = '0;
        match_value = '0;
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            valid_vec[i] = cell_status[i].valid;
            match_vec[i] = cell_status[i].match;
            if (cell_status[i].match)
            begin
                match_rank  = match_rank | cell_status[i].rank;
                match_value = match_value | cell_status[i].value;
            end
        end
    end

    assign any_match = |match_vec;
    assign count_m1  = count_reg - lkv_pkg::CNT_W'(1);

    always_comb
    begin
        cmd.key      = pend_key_reg;
        cmd.value    = pend_value_reg;
        cmd.wr_value = pend_op_reg == lkv_pkg::OP_SET;
        // least recent valid entry holds rank count-1
        cmd.ref_rank = any_match ? match_rank : count_m1[lkv_pkg::RANK_W-1:0];
        if (!exec_go)
        begin
            cmd.mode = lkv_pkg::MODE_NONE;
        end
        else if (any_match)
        begin
            cmd.mode = lkv_pkg::MODE_TOUCH;
        end
        else if (pend_op_reg == lkv_pkg::OP_GET)
        begin
            cmd.mode = lkv_pkg::MODE_NONE;
        end
        else if (count_reg < cap_eff)
        begin
            cmd.mode = lkv_pkg::MODE_INSERT;
        end
        else
        begin
            cmd.mode = lkv_pkg::MODE_REPLACE;
        end
    end

    assign count_next = (cmd.mode == lkv_pkg::MODE_INSERT)
                        ? count_reg + lkv_pkg::CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (exec_go && (pend_op_reg == lkv_pkg::OP_GET))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && (pend_op_reg == lkv_pkg::OP_GET))
        begin
            hit_reg        <= any_match;
            read_value_reg <= any_match ? match_value : '0;
        end
    end

    // cell row; the free chain marks the lowest-numbered empty cell
    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < lkv_pkg::MAX_ENTRIES; g++)
    begin : g_cell
        lkv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .free_in  (free_chain[g]),
            .free_out (free_chain[g+1]),
            .status   (cell_status[g])
        );
    end

    a_count_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg)
    ) else $error("fill count out of step with valid cells");

    a_single_match: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec)
    ) else $error("key present in more than one cell");

    a_insert_has_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.mode == lkv_pkg::MODE_INSERT) |-> !(&valid_vec)
    ) else $error("insert with no free cell");

    a_get_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (exec_go && (pend_op_reg == lkv_pkg::OP_GET)) |=> out_valid_reg
    ) else $error("executed get produced no result");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= lkv_pkg::MAX_ENTRIES
    ) else $error("fill count above table size");

endmodule

@@ tb/sv/lru_key_value_cache_tb.sv @@
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

    localparam int POOL_SIZE     = 24;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 10;
    localparam int CAP_RANDOM    = -1;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AT_ITEM  = 500;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CALM_WINDOW   = 100;
    localparam int CALM_PERIOD   = 512;

    typedef struct {
        logic                      op;
        logic [lkv_pkg::KEY_W-1:0] key;
        logic [lkv_pkg::VAL_W-1:0] value;
    } access_t;

    typedef struct {
        logic                      hit;
        logic [lkv_pkg::VAL_W-1:0] read_value;
    } lookup_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       psel       = 1'b0;
    logic                       penable    = 1'b0;
    logic                       pwrite     = 1'b0;
    logic [lkv_pkg::ADDR_W-1:0] paddr      = '0;
    logic [lkv_pkg::DATA_W-1:0] pwdata     = '0;
    logic [lkv_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic                       op         = lkv_pkg::OP_GET;
    logic [lkv_pkg::KEY_W-1:0]  key        = '0;
    logic [lkv_pkg::VAL_W-1:0]  value      = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic                       hit;
    logic [lkv_pkg::VAL_W-1:0]  read_value;

    lru_key_value_cache DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value)
    );

    // shadow copy of the cache
    logic [lkv_pkg::KEY_W-1:0]  shadow_key      [lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]  shadow_value    [lkv_pkg::MAX_ENTRIES];
    logic                       shadow_valid    [lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::RANK_W-1:0] shadow_rank     [lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::CAP_W-1:0]  shadow_capacity;

    access_t                   pending_q [$];
    lookup_t                   lookup_q  [$];
    logic [lkv_pkg::KEY_W-1:0] key_pool  [POOL_SIZE];

    int   error_count = 0;
    int   items_in    = 0;
    int   cycle_no    = 0;
    logic in_taken    = 1'b0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // slot s becomes rank 0, entries more recent than it age by one
    function automatic void promote(int s);
        logic [lkv_pkg::RANK_W-1:0] r;
        r = shadow_rank[s];
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            if (shadow_valid[i] && i != s && shadow_rank[i] < r)
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        end
        shadow_rank[s] = '0;
    endfunction

    function automatic void lru_access(access_t a);
        int      slot;
        int      free_slot;
        int      victim;
        int      fill;
        int      cap;
        lookup_t res;
        slot      = -1;
        free_slot = -1;
        victim    = -1;
        fill      = 0;
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == a.key)
                slot = i;
        end
        if (a.op == lkv_pkg::OP_GET)
        begin
            res.hit        = (slot >= 0);
            res.read_value = '0;
            if (slot >= 0)
            begin
                res.read_value = shadow_value[slot];
                promote(slot);
            end
            lookup_q.push_back(res);
        end
        else if (slot >= 0)
        begin
            shadow_value[slot] = a.value;
            promote(slot);
        end
        else
        begin
            cap = int'(shadow_capacity);
            if (cap == 0)
                cap = 1;
            if (cap > lkv_pkg::MAX_ENTRIES)
                cap = lkv_pkg::MAX_ENTRIES;
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            begin
                if (shadow_valid[i])
                begin
                    fill++;
                    if (victim < 0 || shadow_rank[i] > shadow_rank[victim])
                        victim = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (fill < cap && free_slot >= 0)
            begin
                for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
                begin
                    if (shadow_valid[i])
                        shadow_rank[i] = shadow_rank[i] + 1'b1;
                end
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot]   = a.key;
                shadow_value[free_slot] = a.value;
                shadow_rank[free_slot]  = '0;
            end
            else if (victim >= 0)
            begin
                shadow_key[victim]   = a.key;
                shadow_value[victim] = a.value;
                promote(victim);
            end
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_access(logic o, logic [lkv_pkg::KEY_W-1:0] k,
                                         logic [lkv_pkg::VAL_W-1:0] v);
        access_t a;
        a.op    = o;
        a.key   = k;
        a.value = v;
        pending_q.push_back(a);
    endfunction

    // mostly keys from a pool a little larger than the capacity, so hits and evictions mix
    function automatic void queue_random(int pool_n);
        int                        r;
        logic [lkv_pkg::KEY_W-1:0] k;
        logic [lkv_pkg::VAL_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 88)
            k = key_pool[$urandom_range(0, pool_n - 1)];
        else if (r < 95)
            k = $urandom;
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 19);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = '1;
        else
            v = $urandom;
        queue_access(($urandom_range(0, 99) < 45) ? lkv_pkg::OP_GET : lkv_pkg::OP_SET, k, v);
    endfunction

    task automatic write_capacity(logic [lkv_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lkv_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_capacity = data[lkv_pkg::CAP_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sets give no result item, so keep waiting for a drain period after the last lookup returns
    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || lookup_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        access_t a;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                a = pending_q.pop_front();
                op       <= a.op;
                key      <= a.key;
                value    <= a.value;
                in_valid <= 1'b1;
                send_gap = ((cycle_no % CALM_PERIOD) < CALM_WINDOW) ? 0 : idle_len();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off so the input side backs up
    always @(negedge clk)
    begin
        if (!hold_done && items_in >= HOLD_AT_ITEM)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ((cycle_no % CALM_PERIOD) >= CALM_WINDOW)
                stall_left = idle_len();
        end
    end

    // monitor: check results first, the item taken at this edge answers later
    always @(posedge clk)
    begin
        lookup_t exp_res;
        access_t a;
        cycle_no <= cycle_no + 1;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    $error("result item with no lookup waiting: hit %0d read_value %h",
                           hit, read_value);
                    error_count++;
                end
                else
                begin
                    exp_res = lookup_q.pop_front();
                    if (hit !== exp_res.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, hit);
                        error_count++;
                    end
                    if (read_value !== exp_res.read_value)
                    begin
                        $error("read_value: expected %h, actual %h",
                               exp_res.read_value, read_value);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                a.op    = op;
                a.key   = key;
                a.value = value;
                lru_access(a);
                items_in++;
            end
        end
    end

    initial
    begin
        int                         phase_caps [NUM_PHASES];
        int                         eff;
        int                         pool_n;
        logic [lkv_pkg::DATA_W-1:0] wdata;
        phase_caps = '{16, 2, 0, 1, 31, 8, 17, CAP_RANDOM, CAP_RANDOM, CAP_RANDOM};
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end
        shadow_capacity = lkv_pkg::CAP_RESET;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty cache, key extremes, update in place, then fill and evict
        queue_access(lkv_pkg::OP_GET, '0, '1);
        queue_access(lkv_pkg::OP_GET, '1, '0);
        queue_access(lkv_pkg::OP_SET, '0, '0);
        queue_access(lkv_pkg::OP_SET, '1, '1);
        queue_access(lkv_pkg::OP_GET, '0, '0);
        queue_access(lkv_pkg::OP_GET, '1, '0);
        queue_access(lkv_pkg::OP_SET, '0, 32'hA5A5_5A5A);
        queue_access(lkv_pkg::OP_GET, '0, '1);
        for (int i = 2; i < lkv_pkg::MAX_ENTRIES; i++)
            queue_access(lkv_pkg::OP_SET, key_pool[i], $urandom);
        // full: the all-ones key is now least recent and gets replaced
        queue_access(lkv_pkg::OP_SET, key_pool[lkv_pkg::MAX_ENTRIES], $urandom);
        queue_access(lkv_pkg::OP_GET, '1, '0);
        queue_access(lkv_pkg::OP_GET, key_pool[lkv_pkg::MAX_ENTRIES], '0);
        wait_idle();

        // capacity 2 right after a full cache drops below the current fill
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wdata = $urandom;
            if (phase_caps[p] == CAP_RANDOM)
                wdata[lkv_pkg::CAP_W-1:0] = lkv_pkg::CAP_W'($urandom_range(0, 31));
            else
                wdata[lkv_pkg::CAP_W-1:0] = lkv_pkg::CAP_W'(phase_caps[p]);
            write_capacity(wdata);
            eff = int'(wdata[lkv_pkg::CAP_W-1:0]);
            if (eff == 0)
                eff = 1;
            if (eff > lkv_pkg::MAX_ENTRIES)
                eff = lkv_pkg::MAX_ENTRIES;
            pool_n = eff + $urandom_range(1, 4);
            if (pool_n > POOL_SIZE)
                pool_n = POOL_SIZE;
            repeat (PHASE_ITEMS) queue_random(pool_n);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("lru_key_value_cache_tb: clean");
        else
            $display("lru_key_value_cache_tb: errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("lru_key_value_cache_tb: errors");
        $finish;
    end

endmodule
